// ----- src/dhoat_pkg.sv -----
// Package for the double-hash open-address table: widths, codes, hash constants.
// No dependencies; used by the front, queue and back parts, top level, checker and bench.
`timescale 1ns / 1ps
`default_nettype none
package dhoat_pkg;
  localparam int TableDepth = 1024;
  localparam int KeyBytes   = 8;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int SizeW      = 11;
  localparam logic [63:0] FnvPrime = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] FnvBasis = 64'hcbf2_9ce4_8422_2325;
  localparam logic [SizeW-1:0] SizeReset = 11'd1021;

  typedef enum logic [1:0] {OP_LOOKUP = 2'd0, OP_INSERT = 2'd1, OP_DELETE = 2'd2,
                            OP_NONE = 2'd3} op_t;
  typedef enum logic [2:0] {ST_HIT = 3'd0, ST_MISS = 3'd1, ST_INSERTED = 3'd2,
                            ST_OVERWRITTEN = 3'd3, ST_DELETED = 3'd4,
                            ST_FULL = 3'd5} status_t;
  localparam logic [1:0] MarkEmpty = 2'd0;
  localparam logic [1:0] MarkLive  = 2'd1;
  localparam logic [1:0] MarkTomb  = 2'd2;

  // Work item handed from the front part to the back part through the queue.
  typedef struct packed {
    logic [1:0]       op;
    logic [63:0]      key;
    logic [31:0]      value;
    logic             builtin;
    logic [IdxW-1:0]  idx;
    logic [SizeW-1:0] step;
    logic [SizeW-1:0] n;
  } job_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [31:0]      found_value;
    logic             found_builtin;
    logic [SizeW-1:0] entry_count;
    logic             over_threshold;
  } result_t;
endpackage
`default_nettype wire

// ----- src/dhoat_if.sv -----
// Channel interfaces of the table: request channel and result channel.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface dhoat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] key;
  logic [31:0] value_handle;
  logic        builtin_flag;
  modport source (output valid, operation, key, value_handle, builtin_flag, input ready);
  modport sink (input valid, operation, key, value_handle, builtin_flag, output ready);
endinterface

interface dhoat_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] found_value;
  logic        found_builtin;
  logic [10:0] entry_count;
  logic        over_threshold;
  modport source (output valid, status, found_value, found_builtin, entry_count,
                  over_threshold, input ready);
  modport sink (input valid, status, found_value, found_builtin, entry_count,
                over_threshold, output ready);
endinterface
`default_nettype wire

// ----- src/dhoat_front.sv -----
// Front part: trims and hashes the key one byte a cycle, then reduces the hash
// modulo N and N-1 bit-serially. Depends on dhoat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dhoat_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [dhoat_pkg::SizeW-1:0] size_cfg,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               in_op,
  input  wire logic [63:0]              in_key,
  input  wire logic [31:0]              in_value,
  input  wire logic                     in_builtin,
  output logic                          job_valid,
  input  wire logic                     job_ready,
  output dhoat_pkg::job_t               job
);
  import dhoat_pkg::*;
  typedef enum logic [1:0] {S_IDLE, S_HASH, S_MOD, S_OUT} fstate_t;
  fstate_t state_r;
  logic [63:0] raw_r, kept_r, h_r, hx, prod;
  logic [3:0]  byte_r;
  logic [6:0]  bit_r;
  logic [SizeW-1:0] n_r, rem_a_r, rem_b_r;
  logic [1:0]  op_r;
  logic [31:0] val_r;
  logic        bi_r;
  logic [7:0]  cur_byte;
  logic [SizeW:0] sa, sb;
  logic [SizeW-1:0] n_eff;

  always_comb begin
    if (size_cfg < SizeW'(3)) n_eff = SizeW'(3);
    else if (size_cfg > SizeW'(TableDepth)) n_eff = SizeW'(TableDepth);
    else n_eff = size_cfg;
  end
  assign cur_byte = raw_r[7:0];
  // The FNV prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
  assign hx = h_r ^ {56'd0, cur_byte};
  assign prod = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4) +
                (hx << 1) + hx;
  // Restoring remainder step: shift in one hash bit, subtract when it fits.
  assign sa = {rem_a_r, h_r[63]};
  assign sb = {rem_b_r, h_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          state_r <= S_HASH;
          raw_r <= in_key; kept_r <= '0; h_r <= FnvBasis; byte_r <= '0;
          op_r <= in_op; val_r <= in_value; bi_r <= in_builtin; n_r <= n_eff;
        end
        S_HASH: begin
          if (cur_byte == 8'd0 || byte_r == 4'(KeyBytes)) begin
            state_r <= S_MOD; bit_r <= '0; rem_a_r <= '0; rem_b_r <= '0;
          end else begin
            h_r <= prod;
            kept_r <= kept_r | ({56'd0, cur_byte} << {byte_r[2:0], 3'b000});
            raw_r <= raw_r >> 8;
            byte_r <= byte_r + 4'd1;
          end
        end
        S_MOD: begin
          rem_a_r <= (sa >= {1'b0, n_r}) ? SizeW'(sa - {1'b0, n_r}) : SizeW'(sa);
          rem_b_r <= (sb >= {1'b0, n_r - SizeW'(1)}) ?
                     SizeW'(sb - {1'b0, n_r - SizeW'(1)}) : SizeW'(sb);
          h_r <= {h_r[62:0], 1'b0};
          bit_r <= bit_r + 7'd1;
          if (bit_r == 7'd63) state_r <= S_OUT;
        end
        S_OUT: if (job_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign job_valid = (state_r == S_OUT);
  always_comb begin
    job.op = op_r; job.key = kept_r; job.value = val_r; job.builtin = bi_r;
    job.idx = IdxW'(rem_a_r); job.step = rem_b_r + SizeW'(1); job.n = n_r;
  end
endmodule
`default_nettype wire

// ----- src/dhoat_queue.sv -----
// Two-entry queue between front and back parts. Depends on dhoat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dhoat_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire dhoat_pkg::job_t wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output dhoat_pkg::job_t      rd_data
);
  import dhoat_pkg::*;
  job_t mem_r [2];
  logic rp_r, wp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      rp_r <= 1'b0; wp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

// ----- src/dhoat_back.sv -----
// Back part: walks the probe sequence through slot memories, applies the
// request and holds the result register. Depends on dhoat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dhoat_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  wire dhoat_pkg::job_t job,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output dhoat_pkg::result_t   res
);
  import dhoat_pkg::*;
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_OUT} bstate_t;
  bstate_t state_r;
  logic [1:0]  mark_mem [TableDepth];
  logic [63:0] key_mem  [TableDepth];
  logic [32:0] val_mem  [TableDepth];
  logic [1:0]  mark_q;
  logic [63:0] key_q;
  logic [32:0] val_q;
  job_t        job_r;
  logic [IdxW-1:0]  idx_r;
  logic [SizeW-1:0] iter_r, count_r;
  logic [IdxW:0]    clr_r;
  logic [SizeW:0]   nxt_sum;
  logic             hit;
  logic [14:0]      ten_c, seven_n;
  logic [2:0]       status_r;
  logic [31:0]      fval_r;
  logic             fbi_r;

  assign hit = (mark_q == MarkLive) && (key_q == job_r.key);
  assign nxt_sum = {1'b0, SizeW'(idx_r)} + {1'b0, job_r.step};

  always_ff @(posedge clk) begin
    mark_q <= mark_mem[idx_r];
    key_q  <= key_mem[idx_r];
    val_q  <= val_mem[idx_r];
    if (state_r == S_CLEAR) mark_mem[clr_r[IdxW-1:0]] <= MarkEmpty;
    if (state_r == S_EVAL) begin
      if (job_r.op == OP_INSERT && mark_q != MarkLive) begin
        mark_mem[idx_r] <= MarkLive;
        key_mem[idx_r]  <= job_r.key;
        val_mem[idx_r]  <= {job_r.builtin, job_r.value};
      end else if (job_r.op == OP_INSERT && hit) begin
        val_mem[idx_r]  <= {job_r.builtin, job_r.value};
      end else if (job_r.op == OP_DELETE && hit) begin
        mark_mem[idx_r] <= MarkTomb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; count_r <= '0; idx_r <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (IdxW + 1)'(TableDepth - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (job_valid) begin
          job_r <= job; idx_r <= job.idx; iter_r <= '0;
          fval_r <= '0; fbi_r <= 1'b0;
          if (job.op == OP_NONE) begin
            status_r <= ST_MISS; state_r <= S_OUT;
          end else begin
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_EVAL;
        S_EVAL: begin
          iter_r <= iter_r + SizeW'(1);
          idx_r <= (nxt_sum >= {1'b0, job_r.n}) ? IdxW'(nxt_sum - {1'b0, job_r.n})
                                                 : IdxW'(nxt_sum);
          if (job_r.op == OP_INSERT && mark_q != MarkLive) begin
            status_r <= ST_INSERTED; count_r <= count_r + SizeW'(1);
            state_r <= S_OUT;
          end else if (job_r.op == OP_INSERT && hit) begin
            status_r <= ST_OVERWRITTEN; state_r <= S_OUT;
          end else if (job_r.op != OP_INSERT && mark_q == MarkEmpty) begin
            status_r <= ST_MISS; state_r <= S_OUT;
          end else if (hit) begin
            state_r <= S_OUT;
            if (job_r.op == OP_LOOKUP) begin
              status_r <= ST_HIT; fval_r <= val_q[31:0]; fbi_r <= val_q[32];
            end else begin
              status_r <= ST_DELETED; count_r <= count_r - SizeW'(1);
            end
          end else if (iter_r == job_r.n - SizeW'(1)) begin
            // Probe ran out of steps.
            status_r <= (job_r.op == OP_INSERT) ? ST_FULL : ST_MISS;
            state_r <= S_OUT;
          end else begin
            state_r <= S_READ;
          end
        end
        S_OUT: if (res_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign ten_c   = 15'(count_r) * 15'd10;
  assign seven_n = 15'(job_r.n) * 15'd7;
  assign res = '{status: status_r, found_value: fval_r, found_builtin: fbi_r,
                 entry_count: count_r, over_threshold: (ten_c > seven_n)};
  assign res_valid = (state_r == S_OUT);
  assign job_ready = (state_r == S_IDLE);
endmodule
`default_nettype wire

// ----- src/double_hash_open_address_table.sv -----
// Top level of the double-hash open-address key/value table.
// Depends on dhoat_pkg, dhoat_if, dhoat_front, dhoat_queue and dhoat_back.
//
//   Channel  Direction  Handshake            Carries
//   in_      sink       valid/ready          operation, key, value_handle, builtin_flag
//   out_     source     valid/ready          status, value, builtin, count, threshold
//   cfg_     APB slave  psel/penable/pready  slot count at address 0
//
// The front part takes a request, hashes one key byte a cycle until it sees the end of
// the key (a zero byte or all eight bytes), then takes h mod N and h mod (N-1) one
// hash bit a cycle and hands the job off; it accepts no new request until the
// hand-off is done. The back part takes a job and for each probe step reads the slot
// and then evaluates it, until a probe step settles the request.
// A full queue holds the front part in its hand-off state, where in_ready stays low;
// a result waiting for out_ready holds the back part. After reset the back part
// clears every slot mark, one slot a cycle, before it takes its first job.
`timescale 1ns / 1ps
`default_nettype none
module double_hash_open_address_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dhoat_req_if.sink        in_ch,
  dhoat_res_if.source      out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import dhoat_pkg::*;
  logic [SizeW-1:0] size_r;
  logic   fq_valid, fq_ready, qb_valid, qb_ready;
  job_t   fq_job, qb_job;
  result_t res;

  // Configuration register: the slot count lives at byte address zero.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {21'd0, size_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SizeReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 3'd0) begin
      size_r <= cfg_pwdata[SizeW-1:0];
    end
  end

  dhoat_front u_front (
    .clk, .rst_n, .size_cfg(size_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.operation),
    .in_key(in_ch.key), .in_value(in_ch.value_handle), .in_builtin(in_ch.builtin_flag),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  dhoat_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
  );

  dhoat_back u_back (
    .clk, .rst_n, .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
  );

  assign out_ch.status         = res.status;
  assign out_ch.found_value    = res.found_value;
  assign out_ch.found_builtin  = res.found_builtin;
  assign out_ch.entry_count    = res.entry_count;
  assign out_ch.over_threshold = res.over_threshold;
endmodule
`default_nettype wire

// ----- src/dhoat_checker.sv -----
// Port-level checker for the table, bound to the top level.
// Depends on dhoat_pkg status codes.
`timescale 1ns / 1ps
`default_nettype none
module dhoat_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [31:0] found_value,
  input wire logic        found_builtin,
  input wire logic [10:0] entry_count,
  input wire logic        cfg_pready
);
  import dhoat_pkg::*;
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result changed while stalled");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= ST_FULL) else $error("bad status code");
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_HIT |-> found_value == 32'd0 && !found_builtin)
    else $error("found value on non-hit");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_count <= 11'd1024) else $error("count out of range");
  a_pready: assert property (@(posedge clk) cfg_pready) else $error("pready low");
endmodule

bind double_hash_open_address_table dhoat_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .found_value(out_ch.found_value),
  .found_builtin(out_ch.found_builtin), .entry_count(out_ch.entry_count),
  .cfg_pready(cfg_pready)
);
`default_nettype wire

// ----- bench/tb_double_hash_open_address_table.sv -----
// Self-checking testbench for the double-hash open-address key/value table.
// Depends on dhoat_pkg, dhoat_if and the double_hash_open_address_table RTL.
`timescale 1ns / 1ps

// Keeps its own copy of the slot store and predicts one result per request.
class table_scoreboard;
  bit [1:0]  mark [dhoat_pkg::TableDepth];
  bit [63:0] slot_key [dhoat_pkg::TableDepth];
  bit [31:0] slot_value [dhoat_pkg::TableDepth];
  bit        slot_builtin [dhoat_pkg::TableDepth];
  int unsigned live_count;
  bit [10:0] size_reg;
  dhoat_pkg::result_t expected_results [$];
  int errors;

  function new();
    foreach (mark[i]) mark[i] = dhoat_pkg::MarkEmpty;
    live_count = 0;
    size_reg = dhoat_pkg::SizeReset;
    errors = 0;
  endfunction

  function void set_size(bit [10:0] v);
    size_reg = v;
  endfunction

  // Works out the result of one accepted request and updates the slot copy.
  function void note_request(bit [1:0] op, bit [63:0] raw, bit [31:0] val, bit bi);
    bit [63:0] h;
    bit [63:0] kept;
    bit [7:0] byte_v;
    int unsigned n;
    int unsigned idx;
    int unsigned stride;
    dhoat_pkg::status_t st;
    dhoat_pkg::result_t r;
    bit [31:0] fval;
    bit fbi;
    h = dhoat_pkg::FnvBasis;
    kept = '0;
    fval = '0;
    fbi = 1'b0;
    // Only the bytes ahead of the first zero byte belong to the key.
    for (int b = 0; b < dhoat_pkg::KeyBytes; b++) begin
      byte_v = raw[8*b +: 8];
      if (byte_v == 8'd0) break;
      kept[8*b +: 8] = byte_v;
      h = (h ^ {56'd0, byte_v}) * dhoat_pkg::FnvPrime;
    end
    n = size_reg;
    if (n < 3) n = 3;
    if (n > dhoat_pkg::TableDepth) n = dhoat_pkg::TableDepth;
    idx = int'(h % 64'(n));
    stride = 1 + int'(h % 64'(n - 1));
    st = (op == dhoat_pkg::OP_INSERT) ? dhoat_pkg::ST_FULL : dhoat_pkg::ST_MISS;
    if (op != dhoat_pkg::OP_NONE) begin
      for (int i = 0; i < n; i++) begin
        if (op == dhoat_pkg::OP_INSERT) begin
          if (mark[idx] != dhoat_pkg::MarkLive) begin
            mark[idx] = dhoat_pkg::MarkLive;
            slot_key[idx] = kept;
            slot_value[idx] = val;
            slot_builtin[idx] = bi;
            live_count = (live_count + 1) & 11'h7ff;
            st = dhoat_pkg::ST_INSERTED;
            break;
          end
          if (slot_key[idx] == kept) begin
            slot_value[idx] = val;
            slot_builtin[idx] = bi;
            st = dhoat_pkg::ST_OVERWRITTEN;
            break;
          end
        end else begin
          if (mark[idx] == dhoat_pkg::MarkEmpty) break;
          if (mark[idx] == dhoat_pkg::MarkLive && slot_key[idx] == kept) begin
            if (op == dhoat_pkg::OP_LOOKUP) begin
              st = dhoat_pkg::ST_HIT;
              fval = slot_value[idx];
              fbi = slot_builtin[idx];
            end else begin
              mark[idx] = dhoat_pkg::MarkTomb;
              live_count = (live_count - 1) & 11'h7ff;
              st = dhoat_pkg::ST_DELETED;
            end
            break;
          end
        end
        idx += stride;
        if (idx >= n) idx -= n;
      end
    end
    r.status = st;
    r.found_value = fval;
    r.found_builtin = fbi;
    r.entry_count = live_count[10:0];
    r.over_threshold = (10 * live_count > 7 * n);
    expected_results.push_back(r);
  endfunction

  function void check_result(dhoat_pkg::result_t got);
    dhoat_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $error("result with no request outstanding: status %0d", got.status);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.found_value !== want.found_value) begin
      $error("found_value: expected %h, got %h", want.found_value, got.found_value);
      errors++;
    end
    if (got.found_builtin !== want.found_builtin) begin
      $error("found_builtin: expected %b, got %b", want.found_builtin, got.found_builtin);
      errors++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      errors++;
    end
    if (got.over_threshold !== want.over_threshold) begin
      $error("over_threshold: expected %b, got %b", want.over_threshold, got.over_threshold);
      errors++;
    end
  endfunction
endclass

module tb_double_hash_open_address_table;
  import dhoat_pkg::*;

  // The slot-count register sits at byte address 0.
  localparam logic [2:0] RegTableSize = 3'd0;
  // Generous ceiling: several times a run in which every request walks a full
  // probe of the largest table under the heaviest idling.
  localparam int CycleLimit = 10_000_000;
  localparam int PoolMax = 40;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  dhoat_req_if req_ch();
  dhoat_res_if res_ch();

  double_hash_open_address_table dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(req_ch),
    .out_ch(res_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  table_scoreboard sb;

  // Idle percentages for the request side and the result side, changed per phase.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Number of cycles for which the result side holds ready low; counted down
  // by the ready process itself.
  int unsigned hold_cycles;
  int unsigned cycle_count;

  // Key pool of the current phase: the kept bytes and their length.
  bit [63:0] pool_key [PoolMax];
  int unsigned pool_len [PoolMax];
  int unsigned pool_size;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run ceiling, independent of any handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: ready changes at the falling edge; a long hold-off wins over
  // the random idling.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      res_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result taken at a rising edge is compared with the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.status = res_ch.status;
      got.found_value = res_ch.found_value;
      got.found_builtin = res_ch.found_builtin;
      got.entry_count = res_ch.entry_count;
      got.over_threshold = res_ch.over_threshold;
      sb.check_result(got);
    end
  end

  // Offers one request, idling first at random. Called and left at a falling
  // edge; valid stays high on return so back-to-back requests need no toggle.
  task automatic send_request(op_t op, bit [63:0] key, bit [31:0] val, bit bi);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.key <= key;
    req_ch.value_handle <= val;
    req_ch.builtin_flag <= bi;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, key, val, bi);
    @(negedge clk);
  endtask

  // Drops valid and waits until every predicted result has come back; then waits on
  // so the block is surely idle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // APB write of the slot count, then a read-back of the same register.
  task automatic write_table_size(bit [31:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= RegTableSize;
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_size(v[10:0]);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[10:0] !== v[10:0]) begin
      $error("slot_count: expected %h, got %h", v[10:0], cfg_prdata[10:0]);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Raw key for pool entry j: the kept bytes, a zero byte to end them when fewer than
  // eight, then fresh junk that the block must ignore.
  function automatic bit [63:0] raw_key(int unsigned j);
    bit [63:0] k;
    k = {$urandom, $urandom};
    for (int b = 0; b < 8; b++) begin
      if (b < pool_len[j]) k[8*b +: 8] = pool_key[j][8*b +: 8];
      else if (b == pool_len[j]) k[8*b +: 8] = 8'd0;
    end
    return k;
  endfunction

  // Fills the key pool with keys of random length and nonzero bytes.
  task automatic new_pool(int unsigned count);
    pool_size = count;
    for (int j = 0; j < count; j++) begin
      pool_len[j] = $urandom_range(8);
      pool_key[j] = '0;
      for (int b = 0; b < 8; b++)
        pool_key[j][8*b +: 8] = $urandom_range(255, 1);
    end
  endtask

  // Random requests over the pool: inserts lead so that lookups and deletes
  // find live keys; a few unknown operations and junk keys mixed in.
  task automatic random_phase(int unsigned items);
    int unsigned roll;
    op_t op;
    bit [63:0] k;
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) op = OP_INSERT;
      else if (roll < 75) op = OP_LOOKUP;
      else if (roll < 95) op = OP_DELETE;
      else op = OP_NONE;
      if ($urandom_range(19) == 0) k = {$urandom, $urandom};
      else k = raw_key($urandom_range(pool_size - 1));
      send_request(op, k, $urandom, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int unsigned sizes [10];
    int unsigned n;
    sb = new();
    sizes = '{7, 3, 13, 0, 1024, 2047, 31, 2, 101, 1021};
    send_idle_pct = 11;
    recv_idle_pct = 57;
    hold_cycles = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_LOOKUP;
    req_ch.key = '0;
    req_ch.value_handle = '0;
    req_ch.builtin_flag = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = RegTableSize;
    cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset size: the empty key, all-ones fields, junk
    // after the key end, overwrite, delete and its tombstone, unknown operation.
    send_request(OP_LOOKUP, 64'd0, 32'd0, 1'b0);
    send_request(OP_INSERT, 64'd0, 32'hffff_ffff, 1'b1);
    send_request(OP_LOOKUP, 64'd0, 32'd0, 1'b0);
    send_request(OP_LOOKUP, 64'hffff_ffff_ffff_ffff, 32'd0, 1'b0);
    send_request(OP_INSERT, 64'hffff_ffff_ffff_ffff, 32'd0, 1'b0);
    send_request(OP_INSERT, 64'hffff_ffff_ffff_ffff, 32'h1234_5678, 1'b1);
    send_request(OP_LOOKUP, 64'hffff_ffff_ffff_ffff, 32'd0, 1'b0);
    send_request(OP_INSERT, 64'hdead_beef_0000_0041, 32'h0000_0041, 1'b0);
    send_request(OP_LOOKUP, 64'h0000_0000_0000_0041, 32'd0, 1'b0);
    send_request(OP_DELETE, 64'h5555_0000_0000_0041, 32'd0, 1'b0);
    send_request(OP_DELETE, 64'h0000_0000_0000_0041, 32'd0, 1'b0);
    send_request(OP_LOOKUP, 64'h0000_0000_0000_0041, 32'd0, 1'b0);
    send_request(OP_NONE, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1);
    send_request(OP_INSERT, 64'h0000_0000_0000_0041, 32'h0000_0042, 1'b1);
    drain();

    // Directed part at the smallest size: fill three slots, then the probe
    // runs out for a new key, while a known key is still overwritten.
    write_table_size(32'd3);
    send_request(OP_INSERT, 64'h11, 32'd1, 1'b0);
    send_request(OP_INSERT, 64'h22, 32'd2, 1'b1);
    send_request(OP_INSERT, 64'h33, 32'd3, 1'b0);
    send_request(OP_INSERT, 64'h44, 32'd4, 1'b1);
    send_request(OP_INSERT, 64'h22, 32'd5, 1'b0);
    send_request(OP_LOOKUP, 64'h44, 32'd0, 1'b0);
    send_request(OP_DELETE, 64'h44, 32'd0, 1'b0);
    send_request(OP_DELETE, 64'h11, 32'd0, 1'b0);
    send_request(OP_LOOKUP, 64'h33, 32'd0, 1'b0);
    send_request(OP_INSERT, 64'h44, 32'd6, 1'b1);
    drain();

    // Random phases across sizes, in range and out of it. Idling runs
    // sender-light first, then receiver-light, then none at all.
    for (int p = 0; p < 10; p++) begin
      if (p == 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 11;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_table_size(sizes[p]);
      n = sizes[p] < 3 ? 3 : (sizes[p] > TableDepth ? TableDepth : sizes[p]);
      new_pool(n + 2 < PoolMax ? n + 2 : PoolMax);
      // A long result-side stall while requests keep coming backs up the block.
      if (p == 2) hold_cycles = 600;
      random_phase(68);
      drain();
    end

    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (sb.expected_results.size() != 0)
        $error("%0d results never arrived", sb.expected_results.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
